@@ hdl/pidsc_pkg.sv @@
// Shared types, constants and saturating helpers for the PID speed controller.
`default_nettype none
package pidsc_pkg;

  localparam logic [30:0] FALL_STEP_MAX = 31'd0;

  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_OUT_MAX  = 3'd3;
  localparam logic [2:0] REG_OUT_MIN  = 3'd4;
  localparam logic [2:0] REG_INT_MAX  = 3'd5;
  localparam logic [2:0] REG_INT_MIN  = 3'd6;
  localparam logic [2:0] REG_RISE_MAX = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_CLAMP, ST_MP, ST_WP, ST_MI, ST_WI,
    ST_MD, ST_WD, ST_DRIVE, ST_OUT
  } pidsc_state_t;

  typedef struct packed {
    logic busy;
    logic [47:0] quotient;
  } pidsc_div_stat_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = S32_MAX;
    else if (v < -34'sh0_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [33:0] d;
    d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    return sat34(d);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [33:0] d;
    d = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    return sat34(d);
  endfunction

endpackage
`default_nettype wire

@@ hdl/pid_speed_controller_top.sv @@
// Top level of the PID speed controller: registers, sequencer and stream ports.
//
//  channel | handshake         | payload
//  s_*     | s_tvalid/s_tready | s_tdata: target[31:0], count_delta[47:32]
//  m_*     | m_tvalid/m_tready | m_tdata: drive, error_now, integral_now
//  cfg_*   | cfg_we            | cfg_index selects register, cfg_data value
//
// A word waits on the 48-step divider only when the default integral limit
// needs it. The shared multiplier is used three times per word. s_tready is
// high only in idle. A stalled result holds the last step until m_tready rises.
// Reset (rst, synchronous) clears all top-level registers but tgt, delta, acc, m_tdata.
`default_nettype none
module pid_speed_controller_top
  import pidsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // target[31:0], count_delta[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // drive[31:0], error_now[63:32], integral_now[95:64]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] kp, ki, kd, out_max, out_min, int_max, int_min;
  logic [30:0]        rise_max;

  logic signed [31:0] stored_target, actual_speed, last_drive;
  logic signed [31:0] error_current, error_previous, integral_sum;
  logic signed [31:0] tgt;
  logic signed [15:0] delta;
  logic signed [33:0] acc;

  pidsc_state_t state, state_next;

  logic               div_start;
  pidsc_div_stat_t    div_stat;
  logic [31:0]        out_max_mag, ki_mag;
  logic               mul_load;
  logic signed [31:0] mul_a, mul_b, mul_q;

  logic [15:0]        delta_mag;
  logic signed [31:0] actual_new, err_new, err_prev_new, int_base, int_pre;
  logic signed [31:0] lim, int_clamped, drive_c;
  logic signed [33:0] rise_top, fall_bot;
  logic               need_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0; ki <= '0; kd <= '0; out_max <= '0; out_min <= '0;
      int_max <= '0; int_min <= '0; rise_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:       kp       <= cfg_data;
        REG_KI:       ki       <= cfg_data;
        REG_KD:       kd       <= cfg_data;
        REG_OUT_MAX:  out_max  <= cfg_data;
        REG_OUT_MIN:  out_min  <= cfg_data;
        REG_INT_MAX:  int_max  <= cfg_data;
        REG_INT_MIN:  int_min  <= cfg_data;
        REG_RISE_MAX: rise_max <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign need_div    = (ki != 32'sd0) && !(int_max > int_min);
  assign out_max_mag = out_max[31] ? 32'd0 - out_max : out_max;
  assign ki_mag      = ki[31] ? 32'd0 - ki : ki;

  pidsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({out_max_mag[31:0], 16'd0}),
    .divisor  (ki_mag),
    .stat     (div_stat)
  );

  pidsc_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a    (mul_a),
    .b    (mul_b),
    .q    (mul_q)
  );

  always_comb begin
    delta_mag  = delta[15] ? 16'd0 - delta : delta;
    actual_new = delta_mag[15] ? S32_MAX : {delta_mag, 16'd0};
    err_new    = qsub(tgt, actual_new);
    err_prev_new = (tgt != stored_target) ? qsub(tgt, actual_speed) : error_current;
    int_base   = (tgt != stored_target) ? 32'sd0 : integral_sum;
    int_pre    = (ki != 32'sd0) ? qadd(int_base, err_new) : 32'sd0;

    lim = (div_stat.quotient > 48'h0000_7FFF_FFFF) ? S32_MAX
                                                    : div_stat.quotient[31:0];
    int_clamped = integral_sum;
    if (ki != 32'sd0) begin
      if (int_max > int_min) begin
        if (int_clamped > int_max) int_clamped = int_max;
        if (int_clamped < int_min) int_clamped = int_min;
      end else begin
        if (int_clamped > lim) int_clamped = lim;
        if (int_clamped < -lim) int_clamped = -lim;
      end
    end

    rise_top = {{2{last_drive[31]}}, last_drive} + {3'd0, rise_max};
    fall_bot = {{2{last_drive[31]}}, last_drive} - {3'd0, FALL_STEP_MAX};
    drive_c  = sat34(acc);
    if (drive_c > out_max) drive_c = out_max;
    if (drive_c < out_min) drive_c = out_min;
    if (rise_max != 31'd0 && $signed({{2{drive_c[31]}}, drive_c}) > rise_top)
      drive_c = rise_top[31:0];
    if (FALL_STEP_MAX != 31'd0 && $signed({{2{drive_c[31]}}, drive_c}) < fall_bot)
      drive_c = fall_bot[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mul_load   = 1'b0;
    mul_a      = kp;
    mul_b      = error_current;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_PREP;
      end
      ST_PREP: begin
        div_start  = need_div;
        state_next = need_div ? ST_DIV : ST_CLAMP;
      end
      ST_DIV:   if (!div_stat.busy) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_MP;
      ST_MP: begin
        mul_load   = 1'b1;
        state_next = ST_WP;
      end
      ST_WP: state_next = ST_MI;
      ST_MI: begin
        mul_load   = 1'b1;
        mul_a      = ki;
        mul_b      = integral_sum;
        state_next = ST_WI;
      end
      ST_WI: state_next = ST_MD;
      ST_MD: begin
        mul_load   = 1'b1;
        mul_a      = kd;
        mul_b      = qsub(error_current, error_previous);
        state_next = ST_WD;
      end
      ST_WD:    state_next = ST_DRIVE;
      ST_DRIVE: state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_target  <= '0;
      actual_speed   <= '0;
      last_drive     <= '0;
      error_current  <= '0;
      error_previous <= '0;
      integral_sum   <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_PREP: begin
          stored_target  <= tgt;
          actual_speed   <= actual_new;
          error_current  <= err_new;
          error_previous <= err_prev_new;
          integral_sum   <= int_pre;
        end
        ST_CLAMP: integral_sum <= int_clamped;
        ST_DRIVE: last_drive   <= drive_c;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      tgt   <= s_tdata[31:0];
      delta <= s_tdata[47:32];
    end
    unique case (state)
      ST_CLAMP: acc <= '0;
      ST_WP, ST_WI, ST_WD: acc <= acc + {{2{mul_q[31]}}, mul_q};
      default: ;
    endcase
    if (state == ST_OUT && (!m_tvalid || m_tready))
      m_tdata <= {integral_sum, error_current, last_drive};
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_PREP)
    else $error("accepted word did not start a step");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && (!m_tvalid || m_tready) |=> m_tvalid && state == ST_IDLE)
    else $error("result not issued");

endmodule
`default_nettype wire

@@ hdl/pidsc_mul.sv @@
// Shared signed 32x32 multiplier with registered product and Q16.16 saturation.
`default_nettype none
module pidsc_mul
  import pidsc_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod;
  logic signed [47:0] shifted;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * b;
    end
  end

  always_comb begin
    shifted = prod[63:16];
    if (shifted > 48'sh0000_7FFF_FFFF) q = S32_MAX;
    else if (shifted < -48'sh0000_8000_0000) q = S32_MIN;
    else q = shifted[31:0];
  end

endmodule
`default_nettype wire

@@ hdl/pidsc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module pidsc_div
  import pidsc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [47:0]     dividend,
  input  logic [31:0]     divisor,
  output pidsc_div_stat_t stat
);

  logic [47:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {rem, quo[47]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd47;
    end else if (busy) begin
      if (cnt == 6'd0) busy <= 1'b0;
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign stat.busy     = busy;
  assign stat.quotient = quo;

endmodule
`default_nettype wire
